[hw/rtl/wbps_pkg.sv]
// Shared constants, register codes and result type for the wildcard byte
// pattern search unit. No dependencies.
package wbps_pkg;

	localparam int MAX_PATTERN_DEF    = 16;
	localparam int POSITION_WIDTH_DEF = 32;

	// Fixed field widths
	localparam int PAT_BYTES = 16;
	localparam int LEN_W     = 5;
	localparam int CFG_W     = 64;
	localparam int IDX_W     = 3;
	localparam int POS_W     = 32;

	typedef enum logic [IDX_W-1:0] {
		REG_PATTERN_LOW  = 3'd0,
		REG_PATTERN_HIGH = 3'd1,
		REG_CARE_MASK    = 3'd2,
		REG_PATTERN_LEN  = 3'd3,
		REG_START_OFFSET = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic             found;
		logic [POS_W-1:0] position;
	} result_t;

endpackage

[hw/rtl/wbps_cell.sv]
// One window cell: holds a stream byte, compares the byte moving in against
// its pattern byte and extends the match chain. Depends on nothing.
module wbps_cell (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       shift,
	input  logic       clear,
	input  logic [7:0] byte_in,
	input  logic [7:0] pat_byte,
	input  logic       care,
	input  logic       active,
	input  logic       hit_in,
	output logic [7:0] byte_out,
	output logic       hit_out
);

	logic [7:0] byte_q;

	// window byte, zeroed at end of stream
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_q <= '0;
		end else if (shift) begin
			byte_q <= clear ? 8'd0 : byte_in;
		end
	end

	// compare the byte this cell holds after the shift
	assign hit_out  = hit_in & (!active | !care | (byte_in == pat_byte));
	assign byte_out = byte_q;

endmodule

[hw/rtl/wbps_out_buf.sv]
// Two-entry result buffer between the match logic and the output channel.
// Depends on wbps_pkg.
module wbps_out_buf import wbps_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  result_t push_data,
	output logic    full,
	output logic    out_valid,
	input  logic    out_stall,
	output result_t out_data
);

	result_t    ent0_q;
	result_t    ent1_q;
	logic [1:0] cnt_q;
	logic       pop;

	assign pop       = (cnt_q != 2'd0) && !out_stall;
	assign full      = (cnt_q == 2'd2);
	assign out_valid = (cnt_q != 2'd0);
	assign out_data  = ent0_q;

	// occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (push && !pop) begin
			cnt_q <= cnt_q + 2'd1;
		end else if (pop && !push) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	// entries; entry 0 is the head
	always_ff @(posedge clk) begin
		if (push && !pop) begin
			if (cnt_q == 2'd0) begin
				ent0_q <= push_data;
			end else begin
				ent1_q <= push_data;
			end
		end else if (pop && !push) begin
			ent0_q <= ent1_q;
		end else if (pop && push) begin
			if (cnt_q == 2'd1) begin
				ent0_q <= push_data;
			end else begin
				ent0_q <= ent1_q;
				ent1_q <= push_data;
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("result pushed into full buffer");
`endif

endmodule

[hw/rtl/wildcard_byte_pattern_search_unit.sv]
// A result is written into the result buffer on the transfer of the byte that
// completes the match or ends the stream, and offered on out_valid from its head.
// Throughput: one byte per cycle; the compare runs across a chain of window
// cells; in_stall rises only while both result buffer entries are held.
// Reset (arst_n low) clears window, position counter, reported flag and the
// configuration registers to their reset values.
module wildcard_byte_pattern_search_unit import wbps_pkg::*; #(
	parameter int MAX_PATTERN    = MAX_PATTERN_DEF,
	parameter int POSITION_WIDTH = POSITION_WIDTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [7:0]       data_byte,
	input  logic             last_byte,
	output logic             out_valid,
	input  logic             out_stall,
	output logic             found,
	output logic [POS_W-1:0] match_position
);

	localparam logic [LEN_W-1:0] MAXL = LEN_W'(MAX_PATTERN);

	logic [CFG_W-1:0]          pat_low_q;
	logic [CFG_W-1:0]          pat_high_q;
	logic [PAT_BYTES-1:0]      care_q;
	logic [LEN_W-1:0]          len_cfg_q;
	logic [POS_W-1:0]          start_q;
	logic [POSITION_WIDTH-1:0] cnt_q;
	logic                      rg_q;

	logic [LEN_W-1:0]          len;
	logic [7:0]                pat_bytes [PAT_BYTES];
	logic [7:0]                chain_byte [MAX_PATTERN+1];
	logic                      chain_hit [MAX_PATTERN+1];
	logic                      accept;
	logic                      sat;
	logic [POS_W:0]            lim;
	logic                      in_range;
	logic                      hit;
	logic [POSITION_WIDTH-1:0] begin_pos;
	logic                      push;
	logic                      buf_full;
	result_t                   res;
	result_t                   out_res;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_low_q  <= '0;
			pat_high_q <= '0;
			care_q     <= '1;
			len_cfg_q  <= LEN_W'(1);
			start_q    <= '0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_PATTERN_LOW:  pat_low_q  <= cfg_data;
				REG_PATTERN_HIGH: pat_high_q <= cfg_data;
				REG_CARE_MASK:    care_q     <= cfg_data[PAT_BYTES-1:0];
				REG_PATTERN_LEN:  len_cfg_q  <= cfg_data[LEN_W-1:0];
				REG_START_OFFSET: start_q    <= cfg_data[POS_W-1:0];
				default: ;
			endcase
		end
	end

	// used length: zero counts as one, clamp to the window depth
	always_comb begin
		if (len_cfg_q == '0) begin
			len = LEN_W'(1);
		end else if (len_cfg_q > MAXL) begin
			len = MAXL;
		end else begin
			len = len_cfg_q;
		end
	end

	for (genvar b = 0; b < PAT_BYTES / 2; b++) begin : g_pat
		assign pat_bytes[b]                 = pat_low_q[8*b +: 8];
		assign pat_bytes[b + PAT_BYTES / 2] = pat_high_q[8*b +: 8];
	end

	assign accept = in_valid && !in_stall;
	assign in_stall = buf_full;

	// window chain: cell i holds stream byte i places back, matched against
	// pattern byte len-1-i
	assign chain_byte[0] = data_byte;
	assign chain_hit[0]  = 1'b1;

	for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
		logic [LEN_W-1:0] kidx;
		assign kidx = len - LEN_W'(1) - LEN_W'(i);

		wbps_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.shift    (accept),
			.clear    (last_byte),
			.byte_in  (chain_byte[i]),
			.pat_byte (pat_bytes[kidx[3:0]]),
			.care     (care_q[kidx[3:0]]),
			.active   (LEN_W'(i) < len),
			.hit_in   (chain_hit[i]),
			.byte_out (chain_byte[i+1]),
			.hit_out  (chain_hit[i+1])
		);
	end

	// position window: pos+1-len >= start  <=>  pos >= start+len-1
	assign sat       = &cnt_q;
	assign lim       = {1'b0, start_q} + (POS_W+1)'(len - LEN_W'(1));
	assign in_range  = (POS_W+1)'(cnt_q) >= lim;
	assign begin_pos = cnt_q + POSITION_WIDTH'(1) - POSITION_WIDTH'(len);
	assign hit       = !rg_q && !sat && in_range && chain_hit[MAX_PATTERN];

	// result selection
	assign push         = accept && (hit || (last_byte && !rg_q));
	assign res.found    = hit;
	assign res.position = hit ? POS_W'(begin_pos) : '0;

	// stream position and reported flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			rg_q  <= 1'b0;
		end else if (accept) begin
			if (last_byte) begin
				cnt_q <= '0;
				rg_q  <= 1'b0;
			end else begin
				if (!sat) begin
					cnt_q <= cnt_q + POSITION_WIDTH'(1);
				end
				if (hit) begin
					rg_q <= 1'b1;
				end
			end
		end
	end

	wbps_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (res),
		.full      (buf_full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_res)
	);

	assign found          = out_res.found;
	assign match_position = out_res.position;

`ifndef NO_ASSERTIONS
	a_stall_has_data: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with no result waiting");

	a_rearm_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && last_byte) |=> (cnt_q == '0 && !rg_q))
		else $error("stream state not cleared after final byte");

	a_single_result: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && rg_q && !last_byte) |-> !push)
		else $error("second result in one stream");

	a_notfound_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !found) |-> (match_position == '0))
		else $error("not-found result with non-zero position");
`endif

endmodule
